FILE: hdl/mcb_pkg.sv
`default_nettype none

package mcb_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_VERSION       = 2'd0;
  localparam logic [1:0] CFG_CLUSTER_SHIFT = 2'd1;
  localparam logic [1:0] CFG_SECTOR_SHIFT  = 2'd2;
  localparam logic [1:0] CFG_SECTOR_COUNT  = 2'd3;

  // item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BEYOND    = 2'd1;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd2;

  // field widths
  localparam int VER_W     = 8;
  localparam int SHIFT_W   = 5;
  localparam int SC_W      = 48;
  localparam int CFG_W     = 48;
  localparam int LEN_W     = 8;
  localparam int IDX_W     = 17;
  localparam int MLEN_W    = 18;
  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 48;

  // sector count scaled by up to 2^31 before the cluster shift
  localparam int SCALED_W = SC_W + 31;

  // reserved boot region
  localparam int RES_UNIT_V1 = 16384;
  localparam int RES_UNITS   = 31;
  localparam int RES_SPAN    = RES_UNIT_V1 * RES_UNITS;
  localparam int RES_N_W     = 19;
  localparam int RES_FULL_W  = RES_N_W - 3;
  localparam logic [VER_W-1:0] VERSION_V1 = 8'd1;

  // status of one start computation, handed to the control sequencer
  typedef struct packed {
    logic too_large;
    logic alt_skip;
    logic alt_miss;
    logic res_over;
  } geom_flags_t;

endpackage

`default_nettype wire

FILE: hdl/mcb_map_ram.sv
`default_nettype none

module mcb_map_ram #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [mcb_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [mcb_pkg::BYTE_W-1:0] rdata
);

  logic [mcb_pkg::BYTE_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcb_geom.sv
`default_nettype none

module mcb_geom #(
  parameter int MAP_BYTES = 131072,
  parameter int AW        = 17,
  parameter int CW        = 18
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mcb_pkg::VER_W-1:0]     version,
  input  wire logic [mcb_pkg::SHIFT_W-1:0]   cluster_shift,
  input  wire logic [mcb_pkg::SHIFT_W-1:0]   sector_shift,
  input  wire logic [mcb_pkg::SC_W-1:0]      sector_count,
  output logic                               done,
  output mcb_pkg::geom_flags_t               flags,
  output logic [CW-1:0]                      map_count,
  output logic [AW-1:0]                      alt_byte,
  output logic [2:0]                         alt_bit,
  output logic [mcb_pkg::RES_FULL_W-1:0]     res_full,
  output logic [2:0]                         res_rem
);

  localparam int XW   = mcb_pkg::SCALED_W;
  localparam int CLW  = $clog2(MAP_BYTES * 8 + 1);
  localparam int CLW1 = CLW + 1;
  localparam int CIW  = AW + 3;
  localparam logic [CLW:0] LIMIT = CLW1'(MAP_BYTES * 8);

  typedef enum logic [1:0] {G_IDLE, G_CLUS, G_ALT, G_CHECK} gstate_t;

  gstate_t                        state_r;
  logic [XW-1:0]                  x_r;
  logic [mcb_pkg::SC_W-1:0]       scm1_r;
  logic [mcb_pkg::RES_N_W-1:0]    res_n_r;
  logic                           clus_hi_r;
  logic [CLW:0]                   clus_lo_r;
  logic                           too_large_r;
  logic                           alt_hi_r;

  logic [mcb_pkg::SC_W-1:0]       shl_src;
  logic [XW-1:0]                  shl;
  logic [XW-1:0]                  q;
  logic                           rem;
  logic [31:0]                    span_q;
  logic                           span_rem;
  logic [mcb_pkg::RES_N_W-1:0]    res_n_nxt;
  logic                           too_large_nxt;
  logic [CW-1:0]                  count_nxt;

  // shared scaler: sector count (then sector count - 1) times sector size
  assign shl_src = (state_r == G_IDLE) ? sector_count : scm1_r;
  assign shl     = XW'(shl_src) << sector_shift;

  // divide by cluster size, remainder flag for rounding up
  assign q   = x_r >> cluster_shift;
  assign rem = |(x_r & ~({XW{1'b1}} << cluster_shift));

  // reserved cluster count
  assign span_q    = 32'(mcb_pkg::RES_SPAN) >> cluster_shift;
  assign span_rem  = |(32'(mcb_pkg::RES_SPAN) & ~(32'hFFFF_FFFF << cluster_shift));
  assign res_n_nxt = (version == mcb_pkg::VERSION_V1)
                     ? mcb_pkg::RES_N_W'(span_q + 32'(span_rem))
                     : mcb_pkg::RES_N_W'(mcb_pkg::RES_UNITS);

  // map size from cluster count
  assign too_large_nxt = clus_hi_r || (clus_lo_r > LIMIT);
  assign count_nxt     = too_large_nxt ? CW'(MAP_BYTES)
                                       : CW'(CLW1'(clus_lo_r + CLW1'(7)) >> 3);

  assign res_full = res_n_r[mcb_pkg::RES_N_W-1:3];
  assign res_rem  = res_n_r[2:0];

  // start sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= G_IDLE;
      done      <= 1'b0;
      map_count <= '0;
      flags     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        G_IDLE: begin
          if (start) begin
            x_r     <= shl;
            scm1_r  <= sector_count - mcb_pkg::SC_W'(1);
            res_n_r <= res_n_nxt;
            state_r <= G_CLUS;
          end
        end
        G_CLUS: begin
          clus_hi_r <= (q >> CLW) != '0;
          clus_lo_r <= CLW1'(q[CLW-1:0]) + CLW1'(rem);
          x_r       <= shl;
          state_r   <= G_ALT;
        end
        G_ALT: begin
          too_large_r <= too_large_nxt;
          map_count   <= count_nxt;
          alt_hi_r    <= (q >> CIW) != '0;
          alt_byte    <= q[CIW-1:3];
          alt_bit     <= q[2:0];
          state_r     <= G_CHECK;
        end
        G_CHECK: begin
          flags.too_large <= too_large_r;
          flags.alt_skip  <= (sector_count == '0);
          flags.alt_miss  <= alt_hi_r || (32'(alt_byte) >= 32'(map_count));
          flags.res_over  <= ((32'(res_n_r) + 32'd7) >> 3) > 32'(map_count);
          done            <= 1'b1;
          state_r         <= G_IDLE;
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/metadata_cluster_bitmap.sv
// Metadata cluster bitmap: a byte-wide, MSB-first map of clusters held in one
// synchronous RAM of MAP_BYTES bytes, worked one item at a time. A start item
// first has the geometry unit do the size arithmetic, then runs a sweep that
// writes every map byte once (cleared, with the reserved boot clusters filled
// in), then, when it fits, writes the alternate boot cluster. The sweep rate
// of one byte per cycle is set by the RAM write port. A run item computes the
// run end, clips it to the map end and sets up the byte range, then reads and
// writes back each map byte it touches (on the single RAM port pair); a read
// item reads one byte. Each hands off its result once the output register is
// free. RAM contents are meaningless after reset until the first start; the
// map length is zero until then, so no clearing pass is needed after reset. A
// new item is taken while the previous result still waits in the output register.
`default_nettype none

module metadata_cluster_bitmap #(
  parameter int MAP_BYTES = 131072
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [mcb_pkg::CLUSTER_W-1:0]     in_first_cluster,
  input  wire logic [mcb_pkg::LEN_W-1:0]         in_run_length,
  input  wire logic [mcb_pkg::IDX_W-1:0]         in_byte_index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic [mcb_pkg::BYTE_W-1:0]             out_map_byte,
  output logic [mcb_pkg::MLEN_W-1:0]             out_map_length,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [mcb_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CW  = $clog2(MAP_BYTES + 1);
  localparam int CIW = AW + 3;
  localparam int LW  = CW + 3;
  localparam int EW  = mcb_pkg::CLUSTER_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_GEOM, S_SWEEP, S_ALT, S_RUN_ADD, S_RUN_CLIP, S_RUN_SETUP,
    S_RMW_RD, S_RMW_WR, S_READ, S_FIN
  } state_t;

  // configuration registers
  logic [mcb_pkg::VER_W-1:0]    version_r;
  logic [mcb_pkg::SHIFT_W-1:0]  cluster_shift_r;
  logic [mcb_pkg::SHIFT_W-1:0]  sector_shift_r;
  logic [mcb_pkg::SC_W-1:0]     sector_count_r;

  // sequencer state
  state_t                          state_r;
  logic [mcb_pkg::CLUSTER_W-1:0]   first_r;
  logic [mcb_pkg::LEN_W-1:0]       len_r;
  logic [EW-1:0]                   end_r;
  logic                            beyond_r;
  logic                            fail_r;
  logic                            empty_r;
  logic [CIW-1:0]                  eff_r;
  logic [AW-1:0]                   cur_r;
  logic [AW-1:0]                   last_r;
  logic [3:0]                      lo_r;
  logic [3:0]                      hi_r;
  logic [1:0]                      res_status_r;
  logic [mcb_pkg::BYTE_W-1:0]      res_byte_r;
  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [mcb_pkg::BYTE_W-1:0]      out_map_byte_r;
  logic [mcb_pkg::MLEN_W-1:0]      out_map_length_r;

  // geometry unit and RAM hookup
  logic                            geom_start;
  logic                            geom_done;
  mcb_pkg::geom_flags_t            geom_flags;
  logic [CW-1:0]                   map_count;
  logic [AW-1:0]                   alt_byte;
  logic [2:0]                      alt_bit;
  logic [mcb_pkg::RES_FULL_W-1:0]  res_full;
  logic [2:0]                      res_rem;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [mcb_pkg::BYTE_W-1:0]      mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic [mcb_pkg::BYTE_W-1:0]      mem_rdata;

  logic                            in_xfer;
  logic                            out_free;
  logic                            read_in_map;
  logic [LW-1:0]                   limit;
  logic                            run_over;
  logic [CIW-1:0]                  last_cl;
  logic                            alt_write;
  logic [3:0]                      lo_eff;
  logic [3:0]                      hi_eff;

  // bits for cluster offsets lo .. hi-1 of one byte, MSB is offset zero
  function automatic logic [7:0] bit_span(input logic [3:0] lo, input logic [3:0] hi);
    bit_span = (8'hFF >> lo) & ~(8'hFF >> hi);
  endfunction

  // reserved-region contents of map byte b right after a start
  function automatic logic [7:0] res_mask(input logic [AW-1:0] b,
                                          input logic [mcb_pkg::RES_FULL_W-1:0] full,
                                          input logic [2:0] rem);
    if (32'(b) < 32'(full)) begin
      res_mask = 8'hFF;
    end else if (32'(b) == 32'(full)) begin
      res_mask = ~(8'hFF >> rem);
    end else begin
      res_mask = 8'h00;
    end
  endfunction

  mcb_geom #(
    .MAP_BYTES (MAP_BYTES),
    .AW        (AW),
    .CW        (CW)
  ) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (geom_start),
    .version       (version_r),
    .cluster_shift (cluster_shift_r),
    .sector_shift  (sector_shift_r),
    .sector_count  (sector_count_r),
    .done          (geom_done),
    .flags         (geom_flags),
    .map_count     (map_count),
    .alt_byte      (alt_byte),
    .alt_bit       (alt_bit),
    .res_full      (res_full),
    .res_rem       (res_rem)
  );

  mcb_map_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake
  assign in_ready       = (state_r == S_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_map_byte   = out_map_byte_r;
  assign out_map_length = out_map_length_r;

  assign geom_start  = in_xfer && (in_mode == mcb_pkg::MODE_START);
  assign read_in_map = 32'(in_byte_index) < 32'(map_count);

  // run clipping against the map end
  assign limit    = {map_count, 3'b000};
  assign run_over = end_r > EW'(limit);
  assign last_cl  = eff_r - CIW'(1);

  // alternate boot cluster goes in only when reserved marking completed, it is not skipped and it lies inside the map
  assign alt_write = !geom_flags.res_over && !geom_flags.alt_skip && !geom_flags.alt_miss;

  // per-byte mark span inside a run
  assign lo_eff = lo_r;
  assign hi_eff = (cur_r == last_r) ? hi_r : 4'd8;

  // RAM port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = res_mask(cur_r, res_full, res_rem);
    mem_re    = 1'b0;
    mem_raddr = cur_r;
    unique case (state_r)
      S_SWEEP: begin
        mem_we = 1'b1;
      end
      S_ALT: begin
        mem_we    = alt_write;
        mem_waddr = alt_byte;
        mem_wdata = res_mask(alt_byte, res_full, res_rem) | (8'h80 >> alt_bit);
      end
      S_RMW_RD: begin
        mem_re = 1'b1;
      end
      S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | bit_span(lo_eff, hi_eff);
      end
      S_IDLE: begin
        mem_re    = in_xfer && (in_mode == mcb_pkg::MODE_READ) && read_in_map;
        mem_raddr = AW'(in_byte_index);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r       <= 8'd3;
      cluster_shift_r <= 5'd12;
      sector_shift_r  <= 5'd9;
      sector_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcb_pkg::CFG_VERSION:       version_r       <= cfg_data[mcb_pkg::VER_W-1:0];
        mcb_pkg::CFG_CLUSTER_SHIFT: cluster_shift_r <= cfg_data[mcb_pkg::SHIFT_W-1:0];
        mcb_pkg::CFG_SECTOR_SHIFT:  sector_shift_r  <= cfg_data[mcb_pkg::SHIFT_W-1:0];
        mcb_pkg::CFG_SECTOR_COUNT:  sector_count_r  <= cfg_data[mcb_pkg::SC_W-1:0];
        default:                    version_r       <= version_r;
      endcase
    end
  end

  // item sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            first_r      <= in_first_cluster;
            len_r        <= in_run_length;
            res_status_r <= mcb_pkg::STAT_OK;
            res_byte_r   <= '0;
            priority if (in_mode == mcb_pkg::MODE_START) begin
              state_r <= S_GEOM;
            end else if (in_mode == mcb_pkg::MODE_RUN) begin
              state_r <= S_RUN_ADD;
            end else if (in_mode == mcb_pkg::MODE_READ) begin
              if (read_in_map) begin
                state_r <= S_READ;
              end else begin
                res_status_r <= mcb_pkg::STAT_BEYOND;
                state_r      <= S_FIN;
              end
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_GEOM: begin
          if (geom_done) begin
            cur_r   <= '0;
            state_r <= (map_count == '0) ? S_ALT : S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (CW'(cur_r) == map_count - CW'(1)) begin
            state_r <= S_ALT;
          end else begin
            cur_r <= cur_r + AW'(1);
          end
        end
        S_ALT: begin
          if (geom_flags.too_large) begin
            res_status_r <= mcb_pkg::STAT_TOO_LARGE;
          end else if (geom_flags.res_over ||
                       (!geom_flags.alt_skip && geom_flags.alt_miss)) begin
            res_status_r <= mcb_pkg::STAT_BEYOND;
          end else begin
            res_status_r <= mcb_pkg::STAT_OK;
          end
          state_r <= S_FIN;
        end
        S_RUN_ADD: begin
          end_r    <= EW'(first_r) + EW'(len_r);
          beyond_r <= EW'(first_r) >= EW'(limit);
          state_r  <= S_RUN_CLIP;
        end
        S_RUN_CLIP: begin
          fail_r  <= (len_r != '0) && run_over;
          empty_r <= (len_r == '0) || beyond_r;
          eff_r   <= run_over ? CIW'(limit) : CIW'(end_r);
          state_r <= S_RUN_SETUP;
        end
        S_RUN_SETUP: begin
          res_status_r <= fail_r ? mcb_pkg::STAT_BEYOND : mcb_pkg::STAT_OK;
          if (empty_r) begin
            state_r <= S_FIN;
          end else begin
            cur_r   <= first_r[CIW-1:3];
            last_r  <= last_cl[CIW-1:3];
            lo_r    <= {1'b0, first_r[2:0]};
            hi_r    <= {1'b0, last_cl[2:0]} + 4'd1;
            state_r <= S_RMW_RD;
          end
        end
        S_RMW_RD: begin
          state_r <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (cur_r == last_r) begin
            state_r <= S_FIN;
          end else begin
            cur_r   <= cur_r + AW'(1);
            lo_r    <= 4'd0;
            state_r <= S_RMW_RD;
          end
        end
        S_READ: begin
          res_byte_r <= mem_rdata;
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= res_status_r;
            out_map_byte_r   <= res_byte_r;
            out_map_length_r <= mcb_pkg::MLEN_W'(map_count);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // writes stay inside the current map
  a_write_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(map_count)))
    else $error("map write beyond map end");

  // the RAM is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("map read and write overlap");

  // the geometry unit only reports while a start is in progress
  a_geom_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    geom_done |-> (state_r == S_GEOM))
    else $error("geometry result with no start pending");

  // an oversized volume always leaves the map at full capacity
  a_too_large_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == mcb_pkg::STAT_TOO_LARGE))
      |-> (out_map_length_r == mcb_pkg::MLEN_W'(MAP_BYTES)))
    else $error("too-large status without full map length");
`endif

endmodule

`default_nettype wire
